// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, constants, types and the byte classifier for the UTF-8
// decoder with replacement character.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned POS_W  = 16;

    // String length at which the byte offset wraps back to zero
    localparam longint unsigned MAX_STRING_BYTES = 64'd65536;
    localparam logic [POS_W:0]  POS_WRAP =
        (MAX_STRING_BYTES < 64'd65536) ? (POS_W + 1)'(MAX_STRING_BYTES)
                                       : (POS_W + 1)'(65536);

    // Default depth of the queue between front and back end
    localparam int unsigned QUEUE_DEPTH = 2;

    // Code point constants
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_CP2 = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP3 = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP4 = 21'h010000;

    // Role of one byte when seen as a lead byte or a continuation byte
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_CONT  = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_BAD   = 3'd5
    } t_byte_class;

    // One queued item: raw byte, end-of-string flag and its class
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
        t_byte_class       cls;
    } t_queue_item;

    // Back-end status seen at the top level
    typedef struct packed {
        logic       busy;
        logic [1:0] pend_count;
        logic       emit_last;
    } t_back_status;

    function automatic t_byte_class classify(input logic [BYTE_W-1:0] b);
        t_byte_class c;
        if (b[7] == 1'b0) begin
            c = CLS_ASCII;
        end else if (b[7:6] == 2'b10) begin
            c = CLS_CONT;
        end else if (b[7:5] == 3'b110) begin
            c = CLS_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            c = CLS_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/utf8d_if.sv =====
// ----------------------------------------------------------------------------
// utf8d_if
// Valid/ready channels of the decoder: the byte stream in, code points out.
// ----------------------------------------------------------------------------
interface utf8d_byte_if import utf8d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_cp_if import utf8d_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [POS_W-1:0] start_offset;
    logic             is_error;
    logic             last_of_string;

    modport source (output valid, output code_point, output start_offset,
                    output is_error, output last_of_string, input ready);
    modport sink   (input valid, input code_point, input start_offset,
                    input is_error, input last_of_string, output ready);
endinterface

// ===== hw/rtl/utf8d_front.sv =====
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts input bytes, classifies each one and queues it for the back end.
// ----------------------------------------------------------------------------
module utf8d_front import utf8d_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utf8d_byte_if.sink   i_byte,
    output logic         o_q_valid,
    output t_queue_item  o_q_item,
    input  logic         i_q_pop
);

    localparam int unsigned PTR_W = (P_QUEUE_DEPTH > 1) ? $clog2(P_QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_QUEUE_DEPTH);

    t_queue_item      r_mem [P_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push;
    logic             pop;

    // Accept while the queue has room
    assign i_byte.ready = (r_count != CNT_FULL);
    assign push         = i_byte.valid && i_byte.ready;
    assign pop          = i_q_pop;

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].data_byte     <= i_byte.data_byte;
            r_mem[r_wr_ptr].end_of_string <= i_byte.end_of_string;
            r_mem[r_wr_ptr].cls           <= classify(i_byte.data_byte);
        end
    end

endmodule

// ===== hw/rtl/utf8d_back.sv =====
// ----------------------------------------------------------------------------
// utf8d_back
// Holds the pending bytes of an unfinished sequence and runs one decode step
// per cycle: emit a code point or a replacement when output is free, or wait for more bytes.
// ----------------------------------------------------------------------------
module utf8d_back import utf8d_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_queue_item   i_q_item,
    output logic          o_q_pop,
    utf8d_cp_if.source    o_cp,
    output t_back_status  o_status
);

    // Pending bytes and decode state
    logic [BYTE_W-1:0] r_buf_byte [3];
    t_byte_class       r_buf_cls  [3];
    logic [1:0]        r_count;
    logic [POS_W-1:0]  r_pos;
    logic              r_eos;
    logic              r_active;

    // Output register
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic [POS_W-1:0]  r_out_off;
    logic              r_out_err;
    logic              r_out_last;

    // Working view of the buffer for this step
    logic [BYTE_W-1:0] e_byte [4];
    t_byte_class       e_cls  [4];
    logic [2:0]        e_cnt;
    logic              e_eos;

    logic              do_eval;
    logic [2:0]        len;
    logic              bad;
    logic              short_seq;
    logic              wait_more;
    logic [CP_W-1:0]   bits;
    logic [CP_W-1:0]   minimum;
    logic [CP_W-1:0]   cp;
    logic              err;
    logic [2:0]        used;
    logic              last;
    logic              out_free;
    logic              step;
    logic              emit;
    logic [2:0]        remain;
    logic [POS_W:0]    pos_sum;
    logic [POS_W-1:0]  pos_next;
    logic [4*BYTE_W-1:0] byte_vec;
    logic [4*BYTE_W-1:0] byte_shift;
    logic [11:0]       cls_vec;
    logic [11:0]       cls_shift;

    // Append the queued byte when starting a new item
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            e_byte[j] = r_buf_byte[j];
            e_cls[j]  = r_buf_cls[j];
        end
        e_byte[3] = r_buf_byte[2];
        e_cls[3]  = r_buf_cls[2];
        e_cnt     = {1'b0, r_count};
        e_eos     = r_eos;
        if (!r_active) begin
            e_byte[r_count] = i_q_item.data_byte;
            e_cls[r_count]  = i_q_item.cls;
            e_cnt           = {1'b0, r_count} + 3'd1;
            e_eos           = i_q_item.end_of_string;
        end
    end

    assign do_eval = r_active || i_q_valid;

    // Decode the lead byte
    always_comb begin
        case (e_cls[0])
            CLS_ASCII: begin
                len     = 3'd1;
                bits    = {13'd0, e_byte[0]};
                minimum = '0;
            end
            CLS_LEAD2: begin
                len     = 3'd2;
                bits    = {10'd0, e_byte[0][4:0], e_byte[1][5:0]};
                minimum = MIN_CP2;
            end
            CLS_LEAD3: begin
                len     = 3'd3;
                bits    = {5'd0, e_byte[0][3:0], e_byte[1][5:0], e_byte[2][5:0]};
                minimum = MIN_CP3;
            end
            CLS_LEAD4: begin
                len     = 3'd4;
                bits    = {e_byte[0][2:0], e_byte[1][5:0], e_byte[2][5:0], e_byte[3][5:0]};
                minimum = MIN_CP4;
            end
            default: begin
                len     = 3'd0;
                bits    = '0;
                minimum = '0;
            end
        endcase
    end

    // Check the continuation bytes that have arrived
    always_comb begin
        bad = 1'b0;
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < len && 3'(i) < e_cnt && e_cls[i] != CLS_CONT) begin
                bad = 1'b1;
            end
        end
    end

    assign short_seq = (e_cnt < len);
    assign wait_more = (len > 3'd1) && !bad && short_seq && !e_eos;

    // Pick the result and how many bytes it consumes
    always_comb begin
        cp   = REPL_CP;
        err  = 1'b1;
        used = 3'd1;
        if (len == 3'd1) begin
            cp  = bits;
            err = 1'b0;
        end else if (len != 3'd0 && !bad && !short_seq) begin
            if (!(bits < minimum || bits > MAX_CP || (bits >= SURR_LO && bits <= SURR_HI)))
            begin
                cp   = bits;
                err  = 1'b0;
                used = len;
            end
        end
    end

    assign last     = e_eos && (e_cnt == used);
    assign out_free = !r_out_valid || o_cp.ready;
    assign step     = do_eval && (wait_more || out_free);
    assign emit     = do_eval && !wait_more && out_free;
    assign o_q_pop  = step && !r_active;

    // Drop the consumed bytes and advance the offset
    assign remain     = e_cnt - used;
    assign byte_vec   = {e_byte[3], e_byte[2], e_byte[1], e_byte[0]};
    assign cls_vec    = {e_cls[3], e_cls[2], e_cls[1], e_cls[0]};
    assign byte_shift = byte_vec >> ({2'd0, used} * 5'd8);
    assign cls_shift  = cls_vec >> ({1'b0, used} * 4'd3);
    assign pos_sum    = {1'b0, r_pos} + (POS_W + 1)'(used);
    assign pos_next   = (pos_sum >= POS_WRAP) ? POS_W'(pos_sum - POS_WRAP)
                                              : pos_sum[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pos    <= '0;
            r_eos    <= 1'b0;
            r_active <= 1'b0;
        end else if (step) begin
            r_eos <= e_eos;
            if (wait_more) begin
                r_count  <= e_cnt[1:0];
                r_active <= 1'b0;
            end else if (remain == 3'd0) begin
                r_count  <= '0;
                r_active <= 1'b0;
                r_pos    <= e_eos ? '0 : pos_next;
            end else begin
                r_count  <= remain[1:0];
                r_active <= 1'b1;
                r_pos    <= pos_next;
            end
        end
    end

    // Hold the pending bytes
    always_ff @(posedge i_clk) begin
        if (step) begin
            for (int j = 0; j < 3; j++) begin
                if (wait_more) begin
                    r_buf_byte[j] <= e_byte[j];
                    r_buf_cls[j]  <= e_cls[j];
                end else begin
                    r_buf_byte[j] <= byte_shift[j*BYTE_W +: BYTE_W];
                    r_buf_cls[j]  <= t_byte_class'(cls_shift[j*3 +: 3]);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_cp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_cp   <= cp;
            r_out_off  <= r_pos;
            r_out_err  <= err;
            r_out_last <= last;
        end
    end

    assign o_cp.valid          = r_out_valid;
    assign o_cp.code_point     = r_out_cp;
    assign o_cp.start_offset   = r_out_off;
    assign o_cp.is_error       = r_out_err;
    assign o_cp.last_of_string = r_out_last;

    assign o_status.busy       = r_active;
    assign o_status.pend_count = r_count;
    assign o_status.emit_last  = emit && last;

endmodule

// ===== hw/rtl/utf8_decoder_with_replacement.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_with_replacement
// UTF-8 byte stream to code points, with U+FFFD on malformed input.
// ----------------------------------------------------------------------------
// Bytes enter one per accepted item and are classified into a short queue
// (P_QUEUE_DEPTH items deep); the back end runs one decode step per cycle.
// A byte that completes a sequence, or that only extends a pending one,
// takes one cycle. A byte that gives k results (replacements for a bad or
// truncated sequence, or the flush of pending bytes at end of string)
// takes k cycles, one per result, set by the single decode step of the back
// end, and one cycle more when the bytes left after the last of them begin
// a sequence that is still unfinished and must wait for the next item.
// These figures hold while the result channel keeps up; a result waiting
// in the output register stalls the decode step. Each result carries the
// byte offset of its first byte within the string, an error flag and a
// mark on the last result of the string; the offset wraps at the smaller
// of MAX_STRING_BYTES and 65536. Results sit in an output register, so the
// queue keeps filling while a result waits.
module utf8_decoder_with_replacement import utf8d_pkg::*; #(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8d_byte_if.sink  i_byte,
    utf8d_cp_if.source  o_cp
);

    logic         q_valid;
    t_queue_item  q_item;
    logic         q_pop;
    t_back_status status;

    utf8d_front #(
        .P_QUEUE_DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    utf8d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_cp      (o_cp),
        .o_status  (status)
    );

`ifndef ASSERT_OFF
    // Never take an item from an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // A step still in progress always has bytes left to examine
    a_busy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.busy |-> (status.pend_count != 2'd0))
        else $error("decode step active with empty buffer");

    // The last result of a string leaves the buffer drained
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.emit_last |=> (status.pend_count == 2'd0) && !status.busy)
        else $error("buffer not drained after end of string");
`endif

endmodule
